// ===== rtl/rdacc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdacc_pkg: shared types and constants for the RMS deviation accumulator
// Field widths, arithmetic widths, transaction structs and the squaring phase.
// ----------------------------------------------------------------------------
package rdacc_pkg;

   // Set size limit and coordinate width
   localparam int MAX_PAIRS  = 65536;
   localparam int COORD_BITS = 20;

   // Accumulator and result widths
   localparam int SUM_W    = 60;
   localparam int COUNT_W  = 17;
   localparam int DEV_W    = 22;
   localparam int SQUARE_W = 2 * COORD_BITS;

   // Divide / square root datapath widths
   localparam int ROOT_W = SUM_W / 2;
   localparam int REM_W  = ROOT_W + 4;
   localparam int UNIT_W = REM_W + 2;
   localparam int STEP_W = $clog2(SUM_W);

   // Axis handled by the shared squarer in each cycle of a pair
   typedef enum logic [1:0] {
      PHASE_X,
      PHASE_Y,
      PHASE_Z,
      PHASE_LAST
   } phase_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic signed [COORD_BITS-1:0] first_z;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
      logic signed [COORD_BITS-1:0] second_z;
      logic                         final_pair;
   } req_type;

   typedef struct packed {
      logic [DEV_W-1:0]   deviation;
      logic [COUNT_W-1:0] pair_count;
      logic               count_overflow;
   } rsp_type;

endpackage

// ===== rtl/rms_deviation_accumulator.sv =====
// ----------------------------------------------------------------------------
// rms_deviation_accumulator: root mean square deviation of two point sets
// Accumulates squared coordinate differences of matching point pairs and, on
// the final pair, returns floor(sqrt(floor(sum / count))) with the count.
// ----------------------------------------------------------------------------
// Each request transaction carries one pair of matching points in signed
// fixed point with 8 fraction bits. A pair that does not end the set holds
// the block busy, stalling requests, while one shared squarer handles x, y and
// z in turn and each square is added into the 60-bit saturating sum. For the
// final pair, after the sum is complete, one compare-subtract unit produces
// the 60 quotient bits of sum / count one per cycle and then the 30 root bits
// one per cycle; the block then notes the finished root and loads the
// response, later if the previous response is still stalled. The response
// transaction is held in an output register, so the next set can start while
// it waits.
// Pairs beyond 65536 in one set are dropped and flagged by count_overflow.
// State clears after each response.
module rms_deviation_accumulator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rdacc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rdacc_pkg::rsp_type rsp_data
);

   localparam int SW  = rdacc_pkg::SUM_W;
   localparam int CW  = rdacc_pkg::COUNT_W;
   localparam int DW  = rdacc_pkg::DEV_W;
   localparam int SXW = rdacc_pkg::SUM_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_LAUNCH,
      ST_ROOT,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   rdacc_pkg::phase_type phase_ff, phase_in;
   rdacc_pkg::req_type   pair_ff, pair_in;
   logic                 final_ff, final_in;
   logic                 add_en_ff, add_en_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [CW-1:0]        pairs_ff, pairs_in;
   logic                 overflow_ff, overflow_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rdacc_pkg::rsp_type   rsp_ff, rsp_in;

   logic [rdacc_pkg::SQUARE_W-1:0] product;
   logic [SXW-1:0]                 sum_wide;
   logic [SW-1:0]                  sum_sat;
   logic                           pairs_full;
   logic                           root_start;
   logic                           root_done;
   logic [rdacc_pkg::ROOT_W-1:0]   root;

   rdacc_sqdiff u_sqdiff (
      .clock   (clock),
      .pair    (pair_ff),
      .phase   (phase_ff),
      .product (product)
   );

   rdacc_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .sum   (sum_ff),
      .count (pairs_ff),
      .done  (root_done),
      .root  (root)
   );

   // Saturating add of one square into the running sum
   always_comb begin
      sum_wide   = {1'b0, sum_ff} + SXW'(product);
      sum_sat    = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
      pairs_full = pairs_ff == CW'(rdacc_pkg::MAX_PAIRS);
   end

   // Sequence accumulation and the end of a set
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pair_in      = pair_ff;
      final_in     = final_ff;
      add_en_in    = add_en_ff;
      sum_in       = sum_ff;
      pairs_in     = pairs_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      root_start   = 1'b0;

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pair_in  = req_data;
               final_in = req_data.final_pair;
               phase_in = rdacc_pkg::PHASE_X;
               state_in = ST_SQUARE;
               // Past the limit the pair only marks overflow
               if (pairs_full) begin
                  overflow_in = 1'b1;
                  add_en_in   = 1'b0;
               end else begin
                  add_en_in = 1'b1;
                  pairs_in  = pairs_ff + 1'b1;
               end
            end
         end
         ST_SQUARE: begin
            if (phase_ff != rdacc_pkg::PHASE_X && add_en_ff) begin
               sum_in = sum_sat;
            end
            unique case (phase_ff)
               rdacc_pkg::PHASE_X: phase_in = rdacc_pkg::PHASE_Y;
               rdacc_pkg::PHASE_Y: phase_in = rdacc_pkg::PHASE_Z;
               rdacc_pkg::PHASE_Z: phase_in = rdacc_pkg::PHASE_LAST;
               rdacc_pkg::PHASE_LAST: begin
                  state_in = final_ff ? ST_LAUNCH : ST_IDLE;
               end
            endcase
         end
         ST_LAUNCH: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Load the response when the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_in.deviation      = root[DW-1:0];
               rsp_in.pair_count     = pairs_ff;
               rsp_in.count_overflow = overflow_ff;
               sum_in                = '0;
               pairs_in              = '0;
               overflow_in           = 1'b0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         pairs_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         pairs_ff     <= pairs_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff  <= phase_in;
      pair_ff   <= pair_in;
      final_ff  <= final_in;
      add_en_ff <= add_en_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/rdacc_sqdiff.sv =====
// ----------------------------------------------------------------------------
// rdacc_sqdiff: shared difference-and-square unit
// Squares the difference of one selected axis per cycle into a register.
// ----------------------------------------------------------------------------
module rdacc_sqdiff (
   input  logic                                clock,
   input  rdacc_pkg::req_type                  pair,
   input  rdacc_pkg::phase_type                phase,
   output logic [rdacc_pkg::SQUARE_W-1:0]      product
);

   localparam int CW = rdacc_pkg::COORD_BITS;

   logic signed [CW-1:0]            coord_a;
   logic signed [CW-1:0]            coord_b;
   logic [CW:0]                     diff;
   logic [CW:0]                     diff_neg;
   logic [CW-1:0]                   mag;
   logic [rdacc_pkg::SQUARE_W-1:0]  product_in;
   logic [rdacc_pkg::SQUARE_W-1:0]  product_ff;

   // Select the axis for this cycle
   always_comb begin
      unique case (phase)
         rdacc_pkg::PHASE_Y: begin
            coord_a = pair.first_y;
            coord_b = pair.second_y;
         end
         rdacc_pkg::PHASE_Z: begin
            coord_a = pair.first_z;
            coord_b = pair.second_z;
         end
         default: begin
            coord_a = pair.first_x;
            coord_b = pair.second_x;
         end
      endcase
   end

   // Take the magnitude of second minus first and square it
   always_comb begin
      diff       = {coord_b[CW-1], coord_b} - {coord_a[CW-1], coord_a};
      diff_neg   = -diff;
      mag        = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];
      product_in = {{CW{1'b0}}, mag} * {{CW{1'b0}}, mag};
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== rtl/rdacc_divsqrt.sv =====
// ----------------------------------------------------------------------------
// rdacc_divsqrt: iterative mean and square root
// One shared compare-subtract unit runs a restoring divide of the sum by the
// count, one quotient bit per cycle, then a digit-by-digit square root of the
// quotient, one root bit per cycle.
// ----------------------------------------------------------------------------
module rdacc_divsqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rdacc_pkg::SUM_W-1:0]        sum,
   input  logic [rdacc_pkg::COUNT_W-1:0]      count,
   output logic                               done,
   output logic [rdacc_pkg::ROOT_W-1:0]       root
);

   localparam int SW = rdacc_pkg::SUM_W;
   localparam int CW = rdacc_pkg::COUNT_W;
   localparam int RW = rdacc_pkg::ROOT_W;
   localparam int MW = rdacc_pkg::REM_W;
   localparam int UW = rdacc_pkg::UNIT_W;
   localparam int TW = rdacc_pkg::STEP_W;

   typedef enum logic [1:0] {
      DS_IDLE,
      DS_DIV,
      DS_SQRT
   } ds_state_type;

   ds_state_type  state_ff, state_in;
   logic [TW-1:0] step_ff, step_in;
   logic [SW-1:0] work_ff, work_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [CW-1:0] divisor_ff, divisor_in;
   logic          done_ff, done_in;

   logic [UW-1:0] op_a;
   logic [UW-1:0] op_b;
   logic [UW:0]   sub;
   logic          ge;

   // Feed the shared compare-subtract unit for the current mode
   always_comb begin
      if (state_ff == DS_SQRT) begin
         op_a = {rem_ff, work_ff[SW-1 -: 2]};
         op_b = UW'({root_ff, 2'b01});
      end else begin
         op_a = UW'({rem_ff[CW-1:0], work_ff[SW-1]});
         op_b = UW'(divisor_ff);
      end
      sub = {1'b0, op_a} - {1'b0, op_b};
      ge  = ~sub[UW];
   end

   // Sequence the divide, then the root
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      unique case (state_ff)
         DS_IDLE: begin
            if (start) begin
               work_in    = sum;
               divisor_in = count;
               rem_in     = '0;
               step_in    = TW'(SW - 1);
               state_in   = DS_DIV;
            end
         end
         DS_DIV: begin
            rem_in  = ge ? sub[MW-1:0] : op_a[MW-1:0];
            work_in = {work_ff[SW-2:0], ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               // Empty count yields a zero mean
               if (divisor_ff == '0) begin
                  work_in = '0;
               end
               rem_in   = '0;
               root_in  = '0;
               step_in  = TW'(RW - 1);
               state_in = DS_SQRT;
            end
         end
         DS_SQRT: begin
            rem_in  = ge ? sub[MW-1:0] : op_a[MW-1:0];
            root_in = {root_ff[RW-2:0], ge};
            work_in = {work_ff[SW-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               done_in  = 1'b1;
               state_in = DS_IDLE;
            end
         end
         default: begin
            state_in = DS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff    <= step_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/rdacc_checker.sv =====
// ----------------------------------------------------------------------------
// rdacc_checker: port-level checks for the RMS deviation accumulator
// Watches the request and response ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module rdacc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input rdacc_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input rdacc_pkg::rsp_type rsp_data
);

   localparam int CW = rdacc_pkg::COUNT_W;

   // No response survives reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Block is busy in the cycle after taking a pair
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on consecutive cycles");

   // Every set reports at least one pair
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pair_count != '0)
      else $error("response with zero pair count");

   // Overflow only with a full count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.count_overflow |->
         rsp_data.pair_count == CW'(rdacc_pkg::MAX_PAIRS))
      else $error("overflow flagged below the pair limit");

endmodule

bind rms_deviation_accumulator rdacc_checker u_rdacc_checker (.*);

// ===== bench/rms_deviation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_deviation_checker: scoreboard for the RMS deviation accumulator
// Watches both channels, keeps its own copy of the running sum, pair count and
// overflow flag, works out the response each final pair must produce, and
// compares every response transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module rms_deviation_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  rdacc_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  rdacc_pkg::rsp_type rsp_data,
   output int                 error_count,
   output int                 results_pending
);
   import rdacc_pkg::*;

   localparam logic [63:0] SUM_CEIL = (64'd1 << SUM_W) - 64'd1;

   // Shadow of the block's accumulation state
   logic [63:0] sum_sq;
   int unsigned pairs_in_set;
   bit          set_overflowed;

   // Deviation results owed by the block, oldest first
   rsp_type     owed_results[$];
   int          errs;

   // Square of the difference of one coordinate pair
   function automatic logic [63:0] diff_square(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
      longint d;
      d = longint'(b) - longint'(a);
      if (d < 0) d = -d;
      return 64'(d * d);
   endfunction

   // Floor of the square root, digit by digit
   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] probe;
      logic [63:0] rest;
      root  = '0;
      probe = 64'd1 << 62;
      rest  = v;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Fold one accepted pair into the sum; on the final pair queue the result
   task automatic take_pair(input req_type p);
      logic [63:0] add;
      logic [63:0] mean;
      logic [63:0] root;
      logic [63:0] count64;
      rsp_type     r;
      if (pairs_in_set >= MAX_PAIRS) begin
         set_overflowed = 1'b1;
      end else begin
         add = diff_square(p.first_x, p.second_x) + diff_square(p.first_y, p.second_y) +
               diff_square(p.first_z, p.second_z);
         if (add > SUM_CEIL || sum_sq > SUM_CEIL - add)
            sum_sq = SUM_CEIL;
         else
            sum_sq = sum_sq + add;
         pairs_in_set++;
      end
      if (p.final_pair) begin
         count64          = 64'(pairs_in_set);
         mean             = (pairs_in_set != 0) ? sum_sq / count64 : '0;
         root             = root_floor(mean);
         r.deviation      = root[DEV_W-1:0];
         r.pair_count     = count64[COUNT_W-1:0];
         r.count_overflow = set_overflowed;
         owed_results     = {owed_results, r};
         sum_sq         = '0;
         pairs_in_set   = 0;
         set_overflowed = 1'b0;
      end
   endtask

   // Count a failure; print only the first few
   task automatic flag(input string what, input longint want, input longint got);
      errs++;
      if (errs <= 10)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         sum_sq         = '0;
         pairs_in_set   = 0;
         set_overflowed = 1'b0;
         owed_results.delete();
      end else begin
         // Check a response transaction against the oldest owed result
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               flag("unexpected response, deviation", -1, rsp_data.deviation);
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.deviation !== want.deviation)
                  flag("deviation", want.deviation, rsp_data.deviation);
               if (rsp_data.pair_count !== want.pair_count)
                  flag("pair_count", want.pair_count, rsp_data.pair_count);
               if (rsp_data.count_overflow !== want.count_overflow)
                  flag("count_overflow", want.count_overflow, rsp_data.count_overflow);
            end
         end
         // Advance the prediction on a request transaction
         if (req_valid && !req_stall) take_pair(req_data);
      end
      error_count     <= errs;
      results_pending <= owed_results.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the RMS deviation accumulator
// Drives point-pair sets with random gaps and response stalls: a short directed
// run, then random sets. A separate checker predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import rdacc_pkg::*;

   localparam int C_MIN        = -(1 << (COORD_BITS - 1));
   localparam int C_MAX        = (1 << (COORD_BITS - 1)) - 1;
   localparam int RANDOM_ITEMS = 1250;
   localparam int IDLE_LIMIT   = 3000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      error_count;
   int      results_pending;
   bit      calm = 1'b0;
   int      idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rms_deviation_accumulator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rms_deviation_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type pair_of(input int fx, input int fy, input int fz,
                                       input int sx, input int sy, input int sz,
                                       input bit last);
      req_type p;
      p.first_x    = fx[COORD_BITS-1:0];
      p.first_y    = fy[COORD_BITS-1:0];
      p.first_z    = fz[COORD_BITS-1:0];
      p.second_x   = sx[COORD_BITS-1:0];
      p.second_y   = sy[COORD_BITS-1:0];
      p.second_z   = sz[COORD_BITS-1:0];
      p.final_pair = last;
      return p;
   endfunction

   // Random pair: full range, close points, equal points, extremes or small values
   function automatic req_type random_pair(input bit last);
      int f[3];
      int s[3];
      int style;
      int pick;
      style = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
         case (style)
            0, 1, 2, 3: begin
               f[a] = $urandom;
               s[a] = $urandom;
            end
            4, 5: begin
               f[a] = $urandom;
               s[a] = f[a] + int'($urandom_range(0, 16)) - 8;
            end
            6: begin
               f[a] = $urandom;
               s[a] = f[a];
            end
            7: begin
               pick = $urandom_range(0, 3);
               f[a] = (pick == 0) ? C_MIN : (pick == 1) ? C_MAX : (pick == 2) ? 0 : -1;
               pick = $urandom_range(0, 3);
               s[a] = (pick == 0) ? C_MIN : (pick == 1) ? C_MAX : (pick == 2) ? 0 : -1;
            end
            default: begin
               f[a] = int'($urandom_range(0, 2048)) - 1024;
               s[a] = int'($urandom_range(0, 2048)) - 1024;
            end
         endcase
      end
      return pair_of(f[0], f[1], f[2], s[0], s[1], s[2], last);
   endfunction

   // Present one pair, after an optional gap, and hold it until accepted
   task automatic send_pair(input req_type p);
      int n;
      n = calm ? 0 : pick_gap();
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
   endtask

   // Response stalls: random lengths, released during calm stretches
   initial begin : stall_driver
      int  hold;
      bit  level;
      hold  = 0;
      level = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            level = calm ? 1'b0 : !level;
            hold  = level ? pick_gap() : $urandom_range(0, 6);
         end
         rsp_stall <= level;
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int sent;
      int set_len;
      int r;
      sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero, extremes, one LSB, floor of the mean, mixed signs
      send_pair(pair_of(0, 0, 0, 0, 0, 0, 1'b1));
      send_pair(pair_of(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1));
      send_pair(pair_of(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 1'b1));
      send_pair(pair_of(C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, 1'b1));
      send_pair(pair_of(0, 0, 0, 1, 0, 0, 1'b1));
      send_pair(pair_of(0, 0, 0, 1, 1, 0, 1'b0));
      send_pair(pair_of(5, 5, 5, 5, 5, 4, 1'b1));
      send_pair(pair_of(-256, 512, -768, 256, -512, 768, 1'b0));
      send_pair(pair_of(C_MAX, 0, -1, -1, 0, C_MAX, 1'b0));
      send_pair(pair_of(123, -456, 789, -321, 654, -987, 1'b1));
      send_pair(pair_of(-1, -1, -1, 0, 0, 0, 1'b1));

      // Random sets of mostly short length
      while (sent < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 7) == 0);
         r = $urandom_range(0, 19);
         if (r < 10)      set_len = $urandom_range(1, 4);
         else if (r < 17) set_len = $urandom_range(5, 12);
         else if (r < 19) set_len = $urandom_range(13, 40);
         else             set_len = 1;
         for (int i = 0; i < set_len; i++) begin
            send_pair(random_pair(i == set_len - 1));
            sent++;
         end
      end
      calm = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain outstanding results, then let the block settle
      do @(negedge clock); while (results_pending != 0);
      repeat (150) @(negedge clock);

      if (error_count == 0 && results_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rdacc_pkg.sv
rtl/rdacc_sqdiff.sv
rtl/rdacc_divsqrt.sv
rtl/rms_deviation_accumulator.sv
rtl/rdacc_checker.sv
bench/rms_deviation_checker.sv
bench/tb.sv
